// ----- rtl/qdec_pkg.sv -----
// Shared types, widths and the transition table of the quadrature decoder.
package qdec_pkg;

  // Fixed field widths
  localparam int unsigned PAIR_W    = 2;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned CHAN_W    = 2;
  localparam int unsigned DETENT_W  = 15;
  localparam int unsigned CODE_W    = 2 * PAIR_W;
  localparam int unsigned CODES     = 1 << CODE_W;

  // Request function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  // Signed step taken for one transition, -2 to +2
  typedef logic signed [2:0] delta_t;

  // Step per code {previous pair, current pair}: single steps move by one,
  // a skipped state moves by two in the fixed direction.
  localparam delta_t DELTA_LUT [CODES] = '{
    3'sd0,  -3'sd1,  3'sd1,  3'sd2,
    3'sd1,   3'sd0, -3'sd2, -3'sd1,
    -3'sd1, -3'sd2,  3'sd0,  3'sd1,
    3'sd2,   3'sd1, -3'sd1,  3'sd0
  };

  // Control from the top level to one encoder channel
  typedef struct packed {
    logic sample_en;
    logic clear;
  } qdec_chan_ctrl_t;

  // Status from one encoder channel
  typedef struct packed {
    logic                reportable;
    logic [DETENT_W-1:0] detent;
  } qdec_chan_stat_t;

endpackage

// ----- rtl/quad_quadrature_decoder.sv -----
// Top level of the four-channel quadrature decoder.
// Decodes up to NUM_ENCODERS quadrature encoders (4x) from an 8-bit pin sample,
// encoder k on bits 2k+1:2k. A request with func 0 updates all channels in
// parallel and gives no report; it is taken every cycle unless a held poll sits
// ahead of it. A request with func 1 polls: each channel from 0 upward that is
// pending with an even position is reported as position/2, last marking the
// final report of that poll, and a poll with nothing to report gives none.
// Requests pass an input register before they are applied; a poll loads its
// reports into a buffer, which they leave at one per cycle while the receiver
// does not stall. A poll holds its input stage (stall), and so every request
// behind it, only while the reports of the previous poll are still waiting,
// which receiver stalls can lengthen.
// No clearing pass is needed after reset.
module quad_quadrature_decoder #(
  parameter int unsigned NUM_ENCODERS = 4,
  parameter int unsigned POS_WIDTH    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            func,
  input  logic [qdec_pkg::SAMPLE_W-1:0]   pin_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [qdec_pkg::CHAN_W-1:0]     channel,
  output logic [qdec_pkg::DETENT_W-1:0]   detent_value,
  output logic                            last
);

  logic                            in_reg_valid;
  logic                            in_reg_func;
  logic [qdec_pkg::SAMPLE_W-1:0]   in_reg_pins;

  logic                            buf_free;
  logic                            sample_en;
  logic                            poll_take;
  logic [NUM_ENCODERS-1:0]         report_mask;
  logic [qdec_pkg::DETENT_W-1:0]   report_value [NUM_ENCODERS];

  qdec_pkg::qdec_chan_ctrl_t       chan_ctrl [NUM_ENCODERS];
  qdec_pkg::qdec_chan_stat_t       chan_stat [NUM_ENCODERS];

  // Hold a poll while the previous reports are still waiting
  assign in_stall  = in_reg_valid & (in_reg_func == qdec_pkg::FUNC_POLL) & ~buf_free;
  assign sample_en = in_reg_valid & (in_reg_func == qdec_pkg::FUNC_SAMPLE);
  assign poll_take = in_reg_valid & (in_reg_func == qdec_pkg::FUNC_POLL) & buf_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_func <= func;
      in_reg_pins <= pin_sample;
    end
  end

  // Encoder channels
  for (genvar k = 0; k < NUM_ENCODERS; k++) begin : g_chan
    assign chan_ctrl[k].sample_en = sample_en;
    assign chan_ctrl[k].clear     = poll_take & chan_stat[k].reportable;
    assign report_mask[k]         = chan_stat[k].reportable;
    assign report_value[k]        = chan_stat[k].detent;

    qdec_channel #(
      .POS_WIDTH (POS_WIDTH)
    ) u_chan (
      .clk  (clk),
      .rst  (rst),
      .ctrl (chan_ctrl[k]),
      .pins (in_reg_pins[2*k +: qdec_pkg::PAIR_W]),
      .stat (chan_stat[k])
    );
  end

  // Report buffer and output
  qdec_report #(
    .NUM_ENCODERS (NUM_ENCODERS)
  ) u_report (
    .clk          (clk),
    .rst          (rst),
    .load         (poll_take),
    .load_mask    (report_mask),
    .load_value   (report_value),
    .free         (buf_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .channel      (channel),
    .detent_value (detent_value),
    .last         (last)
  );

endmodule

// ----- rtl/qdec_channel.sv -----
// One encoder channel: previous pin pair, position counter and pending flag.
module qdec_channel #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  qdec_pkg::qdec_chan_ctrl_t      ctrl,
  input  logic [qdec_pkg::PAIR_W-1:0]    pins,
  output qdec_pkg::qdec_chan_stat_t      stat
);

  logic [qdec_pkg::PAIR_W-1:0] prev_pins;
  logic [POS_WIDTH-1:0]        position;
  logic                        pending;

  logic [qdec_pkg::CODE_W-1:0] code;
  qdec_pkg::delta_t            delta;
  logic                        moved;
  logic [POS_WIDTH-1:0]        position_next;
  logic [POS_WIDTH+15:0]       pos_ext;

  // Look up the step for this transition
  assign code          = {prev_pins, pins};
  assign delta         = qdec_pkg::DELTA_LUT[code];
  assign moved         = (delta != 3'sd0);
  assign position_next = position + {{(POS_WIDTH-3){delta[2]}}, delta};

  // Advance pins, position and pending flag
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins <= '0;
      position  <= '0;
      pending   <= 1'b0;
    end else if (ctrl.sample_en) begin
      prev_pins <= pins;
      if (moved) begin
        position <= position_next;
        pending  <= 1'b1;
      end
    end else if (ctrl.clear) begin
      pending <= 1'b0;
    end
  end

  // Report only whole detents; halve with sign and keep the low bits
  assign pos_ext         = {{16{position[POS_WIDTH-1]}}, position};
  assign stat.reportable = pending & ~position[0];
  assign stat.detent     = pos_ext[qdec_pkg::DETENT_W:1];

endmodule

// ----- rtl/qdec_report.sv -----
// Report buffer: holds the channels found by one poll and sends them in order.
module qdec_report #(
  parameter int unsigned NUM_ENCODERS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [NUM_ENCODERS-1:0]            load_mask,
  input  logic [qdec_pkg::DETENT_W-1:0]      load_value [NUM_ENCODERS],
  output logic                               free,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qdec_pkg::CHAN_W-1:0]        channel,
  output logic [qdec_pkg::DETENT_W-1:0]      detent_value,
  output logic                               last
);

  logic [NUM_ENCODERS-1:0]       mask;
  logic [qdec_pkg::DETENT_W-1:0] value [NUM_ENCODERS];
  logic [NUM_ENCODERS-1:0]       head;
  logic                          pop;

  // Pick the lowest channel still waiting
  assign head      = mask & (~mask + 1'b1);
  assign out_valid = |mask;
  assign last      = ((mask & ~head) == '0);
  assign pop       = out_valid & ~out_stall;
  assign free      = ~out_valid | (pop & last);

  always_comb begin
    channel      = '0;
    detent_value = '0;
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      if (head[k]) begin
        channel      = qdec_pkg::CHAN_W'(k);
        detent_value = value[k];
      end
    end
  end

  // Load a new poll or drop the request just taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= load_mask;
    end else if (pop) begin
      mask <= mask & ~head;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_value;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("report buffer loaded while still holding requests");

  a_no_new_bits: assert property (@(posedge clk) disable iff (rst)
    !load |=> ((mask & ~$past(mask)) == '0))
    else $error("report buffer gained a channel without a poll");

  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> $onehot(mask))
    else $error("last flagged with more than one channel waiting");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !load) |=> ($countones(mask) == $countones($past(mask)) - 1))
    else $error("sent request not dropped from report buffer");
`endif

endmodule

// ----- test/tb_quad_quadrature_decoder.sv -----
// Testbench for the four-channel quadrature decoder: directed table and random traffic.
module tb_quad_quadrature_decoder;

  localparam int unsigned POS_W = 16;
  localparam int unsigned ENCS  = 4;

  // One report as it leaves the block
  typedef struct {
    logic [qdec_pkg::CHAN_W-1:0]   chan;
    logic [qdec_pkg::DETENT_W-1:0] detent;
    logic                          last;
  } report_t;

  // One row of the directed table; a typed row carries its report by hand
  typedef struct {
    logic                          f;
    logic [qdec_pkg::SAMPLE_W-1:0] pins;
    bit                            typed;
    int                            n_typed;
    logic [qdec_pkg::CHAN_W-1:0]   chan;
    logic [qdec_pkg::DETENT_W-1:0] detent;
    logic                          last;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          func = qdec_pkg::FUNC_SAMPLE;
  logic [qdec_pkg::SAMPLE_W-1:0] pin_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [qdec_pkg::CHAN_W-1:0]   channel;
  logic [qdec_pkg::DETENT_W-1:0] detent_value;
  logic                          last;

  // Decoder state as tracked by the testbench
  logic [qdec_pkg::PAIR_W-1:0] prev_pair [ENCS];
  logic [POS_W-1:0]            enc_pos   [ENCS];
  logic [ENCS-1:0]             moved_flags;

  report_t awaited_reports [$];
  int      fault_count = 0;
  int      idle_pct    = 0;
  int      stall_pct   = 0;

  dir_row_t dir_rows [26];

  quad_quadrature_decoder #(
    .NUM_ENCODERS(ENCS),
    .POS_WIDTH   (POS_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .pin_sample  (pin_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .channel     (channel),
    .detent_value(detent_value),
    .last        (last)
  );

  always #1 clk = ~clk;

  task automatic flag_fault(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fault_count++;
  endtask

  // Advance the tracked state by one request and queue the reports it causes
  task automatic decode_request(input logic f, input logic [qdec_pkg::SAMPLE_W-1:0] p,
                                input bit keep);
    logic [qdec_pkg::CODE_W-1:0] code;
    qdec_pkg::delta_t            step;
    report_t                     rep;
    report_t                     batch [$];
    if (f == qdec_pkg::FUNC_SAMPLE) begin
      for (int k = 0; k < ENCS; k++) begin
        code = {prev_pair[k], p[2*k +: 2]};
        case (code)
          4'd2, 4'd4, 4'd11, 4'd13: step = 3'sd1;
          4'd1, 4'd7, 4'd8, 4'd14:  step = -3'sd1;
          4'd3, 4'd12:              step = 3'sd2;
          4'd6, 4'd9:               step = -3'sd2;
          default:                  step = 3'sd0;
        endcase
        if (step != 3'sd0) begin
          enc_pos[k]     = enc_pos[k] + {{(POS_W-3){step[2]}}, step};
          moved_flags[k] = 1'b1;
        end
        prev_pair[k] = p[2*k +: 2];
      end
    end else begin
      // Report moved encoders resting on an even position, lowest first
      for (int k = 0; k < ENCS; k++) begin
        if (moved_flags[k] && !enc_pos[k][0]) begin
          rep.chan       = qdec_pkg::CHAN_W'(k);
          rep.detent     = enc_pos[k][qdec_pkg::DETENT_W:1];
          rep.last       = 1'b0;
          batch.push_back(rep);
          moved_flags[k] = 1'b0;
        end
      end
      if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
      if (keep) foreach (batch[i]) awaited_reports.push_back(batch[i]);
    end
  endtask

  // Offer one request, with a random gap before it, and hold it until taken
  task automatic send_req(input logic f, input logic [qdec_pkg::SAMPLE_W-1:0] p,
                          input bit keep);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid   <= 1'b1;
    func       <= f;
    pin_sample <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_request(f, p, keep);
  endtask

  // Hold off until every awaited report has arrived
  task automatic drain_reports();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_reports.size() != 0);
  endtask

  // Check each report taken against the oldest awaited one, then pick the next stall
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_reports.size() == 0) begin
        flag_fault($sformatf("unexpected report ch %0d detent %h", channel, detent_value));
      end else begin
        want = awaited_reports.pop_front();
        if (channel !== want.chan)
          flag_fault($sformatf("channel %0d, want %0d", channel, want.chan));
        if (detent_value !== want.detent)
          flag_fault($sformatf("ch %0d detent %h, want %h", want.chan, detent_value,
                               want.detent));
        if (last !== want.last)
          flag_fault($sformatf("ch %0d last %b, want %b", want.chan, last, want.last));
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    int                            idle_mix  [4];
    int                            stall_mix [4];
    logic [qdec_pkg::SAMPLE_W-1:0] pins;
    logic [qdec_pkg::PAIR_W-1:0]   pair;
    report_t                       typed_rep;
    int                            r;

    idle_mix  = '{0, 68, 0, 20};
    stall_mix = '{0, 0, 68, 20};
    for (int k = 0; k < ENCS; k++) begin
      prev_pair[k] = '0;
      enc_pos[k]   = '0;
    end
    moved_flags = '0;

    dir_rows = '{
      // nothing to report straight after reset
      '{qdec_pkg::FUNC_POLL,   8'h00, 1'b1, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h00, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h02, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      // odd position stays pending
      '{qdec_pkg::FUNC_POLL,   8'hFF, 1'b1, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h03, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_POLL,   8'h00, 1'b1, 1, 2'd0, 15'd1, 1'b1},
      // flag cleared: second poll is silent
      '{qdec_pkg::FUNC_POLL,   8'h55, 1'b1, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h04, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h0C, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_POLL,   8'h00, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h00, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      // skipped states on every encoder at once
      '{qdec_pkg::FUNC_SAMPLE, 8'hFF, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h00, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hAA, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h55, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hFF, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_POLL,   8'hAA, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h7F, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hBF, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'h3F, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hF3, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_POLL,   8'h00, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hF2, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hF6, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      '{qdec_pkg::FUNC_SAMPLE, 8'hF2, 1'b0, 0, 2'd0, 15'd0, 1'b0},
      // only encoder 1 is even; encoder 0 stays pending
      '{qdec_pkg::FUNC_POLL,   8'hFF, 1'b1, 1, 2'd1, 15'd2, 1'b1}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].f, dir_rows[i].pins, !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].n_typed > 0) begin
        typed_rep.chan   = dir_rows[i].chan;
        typed_rep.detent = dir_rows[i].detent;
        typed_rep.last   = dir_rows[i].last;
        awaited_reports.push_back(typed_rep);
      end
    end
    drain_reports();

    // Random traffic under each idling mix
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int i = 0; i < 108; i++) begin
        if ($urandom_range(0, 49) == 0) drain_reports();
        r = $urandom_range(0, 99);
        if (r < 25) begin
          send_req(qdec_pkg::FUNC_POLL, 8'($urandom), 1'b1);
        end else if (r < 35) begin
          send_req(qdec_pkg::FUNC_SAMPLE, 8'($urandom), 1'b1);
        end else begin
          // Mostly single steps per encoder, with the odd skipped state
          for (int k = 0; k < ENCS; k++) begin
            pair = prev_pair[k];
            r    = $urandom_range(0, 9);
            if (r >= 3 && r < 9) pair[$urandom_range(0, 1)] = ~pair[$urandom_range(0, 1)];
            else if (r == 9)     pair = ~pair;
            pins[2*k +: 2] = pair;
          end
          send_req(qdec_pkg::FUNC_SAMPLE, pins, 1'b1);
        end
      end
      drain_reports();
    end

    stall_pct = 0;
    repeat (12) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qdec_pkg.sv
rtl/qdec_channel.sv
rtl/qdec_report.sv
rtl/quad_quadrature_decoder.sv
test/tb_quad_quadrature_decoder.sv
